/* design/arl_pkg.sv */
// Shared types and constants for the asymmetric ramp limiter.
package arl_pkg;

    localparam int RAMP_W = 16;
    localparam int TIME_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RAMP_W-1:0] RAMP_TIME_RESET = 16'd3000;
    localparam logic [RAMP_W-1:0] RAMP_LENGTH_RESET = 16'd1000;

    // Register index, taken from paddr above the byte offset.
    localparam logic [APB_ADDR_W-3:0] REG_RAMP_TIME = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* design/arl_div.sv */
// Bit-serial restoring divider that yields one quotient bit per cycle.
module arl_div #(
    parameter int DIVIDEND_W = 32,
    parameter int QUOT_W = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_W-1:0]     dividend,
    input  logic [arl_pkg::RAMP_W-1:0] divisor,
    output logic [QUOT_W-1:0]         quotient,
    output arl_pkg::div_stat_t        stat
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam int RW = arl_pkg::RAMP_W;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [RW-1:0]         rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [RW-1:0]         div_reg;

    logic [RW:0]           trial;
    logic [RW:0]           trial_diff;
    logic                  fits;
    logic [RW-1:0]         rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        fits = (trial >= {1'b0, div_reg});
        rem_next = fits ? trial_diff[RW-1:0] : trial[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign quotient = quo_reg[QUOT_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef ASSERT_OFF
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");
`endif

endmodule

/* design/asymmetric_ramp_limiter.sv */
// Top level of the asymmetric ramp limiter with its stream, APB and sequencer logic.
//
// Each input beat carries a target level and a millisecond timestamp and yields one
// output beat with the smoothed level and a ramping flag. A rise of the target starts
// a linear ramp over ramp_time_ms; a fall or a zero ramp time jumps at once. An item
// whose level comes from the ramp formula passes the evaluate, start, divide and output
// states and waits in the divide state for the bit-serial divider, which produces one
// quotient bit per cycle over the LEVEL_WIDTH + 16 bit product; any other item goes
// from evaluate straight to output. The block takes one item at a time and accepts
// the next one while the previous output beat still waits to be taken.
module asymmetric_ramp_limiter #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // target_level, now_ms
    input  logic [((LEVEL_WIDTH+39)/8)*8-1:0] s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // level
    output logic [((LEVEL_WIDTH+7)/8)*8-1:0]  m_tdata,
    // ramping
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [arl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [arl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int LW = LEVEL_WIDTH;
    localparam int RW = arl_pkg::RAMP_W;
    localparam int TW = arl_pkg::TIME_W;
    localparam int PW = LEVEL_WIDTH + arl_pkg::RAMP_W;
    localparam int OUT_W = ((LEVEL_WIDTH + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t          state_reg;
    logic [RW-1:0]   ramp_time_reg;
    logic [LW-1:0]   held_reg;
    logic [LW-1:0]   start_level_reg;
    logic [LW-1:0]   present_reg;
    logic [TW-1:0]   start_stamp_reg;
    logic [RW-1:0]   ramp_len_reg;
    logic [TW-1:0]   now_reg;
    logic [PW-1:0]   prod_reg;
    logic            up_reg;
    logic            ramp_flag_reg;
    logic [LW-1:0]   out_level_reg;
    logic            out_ramp_reg;
    logic            m_tvalid_reg;

    logic [LW-1:0]   in_target;
    logic [TW-1:0]   in_now;
    logic            in_accept;
    logic            cfg_write;
    logic [TW-1:0]   elapsed;
    logic            ramp_over;
    logic            up;
    logic [LW-1:0]   diff;
    logic            div_start;
    logic [LW-1:0]   quotient;
    arl_pkg::div_stat_t div_stat;

    assign in_target = s_tdata[LW-1:0];
    assign in_now = s_tdata[LW+TW-1:LW];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
        && (paddr[arl_pkg::APB_ADDR_W-1:2] == arl_pkg::REG_RAMP_TIME);
    assign prdata = (paddr[arl_pkg::APB_ADDR_W-1:2] == arl_pkg::REG_RAMP_TIME)
        ? arl_pkg::APB_DATA_W'(ramp_time_reg) : '0;

    always_comb
    begin
        elapsed = now_reg - start_stamp_reg;
        ramp_over = (elapsed >= TW'(ramp_len_reg));
        up = (held_reg >= start_level_reg);
        diff = up ? (held_reg - start_level_reg) : (start_level_reg - held_reg);
    end

    assign div_start = (state_reg == ST_START);

    arl_div #(
        .DIVIDEND_W(PW),
        .QUOT_W(LW)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(prod_reg),
        .divisor(ramp_len_reg),
        .quotient(quotient),
        .stat(div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ramp_time_reg <= arl_pkg::RAMP_TIME_RESET;
            held_reg <= '0;
            start_level_reg <= '0;
            present_reg <= '0;
            start_stamp_reg <= '0;
            ramp_len_reg <= arl_pkg::RAMP_LENGTH_RESET;
            now_reg <= '0;
            prod_reg <= '0;
            up_reg <= 1'b0;
            ramp_flag_reg <= 1'b0;
            out_level_reg <= '0;
            out_ramp_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                ramp_time_reg <= pwdata[RW-1:0];
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        now_reg <= in_now;
                        if (in_target != held_reg)
                        begin
                            held_reg <= in_target;
                            start_stamp_reg <= in_now;
                            if ((in_target > present_reg) && (ramp_time_reg != '0))
                            begin
                                start_level_reg <= present_reg;
                                ramp_len_reg <= ramp_time_reg;
                            end
                            else
                            begin
                                start_level_reg <= in_target;
                                present_reg <= in_target;
                                ramp_len_reg <= '0;
                            end
                        end
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    up_reg <= up;
                    prod_reg <= PW'(diff) * PW'(elapsed[RW-1:0]);
                    if (ramp_len_reg == '0)
                    begin
                        ramp_flag_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                    else if (ramp_over)
                    begin
                        ramp_flag_reg <= 1'b0;
                        present_reg <= held_reg;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        ramp_flag_reg <= 1'b1;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        present_reg <= up_reg ? (start_level_reg + quotient)
                                              : (start_level_reg - quotient);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_level_reg <= present_reg;
                        out_ramp_reg <= ramp_flag_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tdata = OUT_W'(out_level_reg);
    assign m_tuser = out_ramp_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("input accepted while previous item still in work");
    a_start_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg >= start_level_reg)
        else $error("ramp start level above held target");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !s_tready && !m_tvalid_reg || div_stat.busy && !s_tready)
        else $error("input ready while divider busy");
`endif

endmodule

/* dv/asymmetric_ramp_limiter_tb.sv */
// Self-checking testbench for the asymmetric ramp limiter with a built-in level predictor.
module asymmetric_ramp_limiter_tb;

    localparam int LEVEL_W = 16;
    localparam int IN_W = ((LEVEL_W + 39) / 8) * 8;
    localparam int OUT_W = ((LEVEL_W + 7) / 8) * 8;

    localparam logic [arl_pkg::APB_ADDR_W-1:0] ADDR_RAMP_TIME =
        {arl_pkg::REG_RAMP_TIME, 2'b00};
    localparam logic [arl_pkg::APB_ADDR_W-3:0] REG_SPARE = 1'b1;
    localparam logic [arl_pkg::APB_ADDR_W-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               ramping;
    } level_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic [IN_W-1:0]                s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [OUT_W-1:0]               m_tdata;
    logic                           m_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [arl_pkg::APB_ADDR_W-1:0] paddr;
    logic [arl_pkg::APB_DATA_W-1:0] pwdata;
    logic [arl_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Predictor state.
    logic [arl_pkg::RAMP_W-1:0] cfg_ramp_time;
    logic [LEVEL_W-1:0]         held_target;
    logic [LEVEL_W-1:0]         slope_base;
    logic [LEVEL_W-1:0]         present_level;
    logic [arl_pkg::TIME_W-1:0] slope_stamp;
    logic [arl_pkg::RAMP_W-1:0] slope_length;

    level_beat_t expected_levels[$];

    int unsigned error_count;
    int unsigned beats_checked;
    int unsigned ramping_beats;
    int unsigned items_sent;
    int unsigned settings_used;
    int unsigned send_idle_pct;
    int unsigned sink_idle_pct;

    asymmetric_ramp_limiter #(
        .LEVEL_WIDTH(LEVEL_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void reset_predictor();
        cfg_ramp_time = arl_pkg::RAMP_TIME_RESET;
        held_target = '0;
        slope_base = '0;
        present_level = '0;
        slope_stamp = '0;
        slope_length = arl_pkg::RAMP_LENGTH_RESET;
    endfunction

    function automatic level_beat_t predict_level(logic [LEVEL_W-1:0] target,
                                                  logic [arl_pkg::TIME_W-1:0] stamp);
        level_beat_t beat;
        logic [arl_pkg::TIME_W-1:0] elapsed;
        logic [63:0] delta;
        beat.ramping = 1'b0;
        if (target != held_target)
        begin
            held_target = target;
            slope_stamp = stamp;
            if (target > present_level && cfg_ramp_time != 0)
            begin
                slope_base = present_level;
                slope_length = cfg_ramp_time;
            end
            else
            begin
                slope_base = target;
                present_level = target;
                slope_length = '0;
            end
        end
        if (slope_length != 0)
        begin
            elapsed = stamp - slope_stamp;
            if (elapsed >= {16'd0, slope_length})
            begin
                present_level = held_target;
            end
            else
            begin
                if (held_target >= slope_base)
                begin
                    delta = (64'(held_target - slope_base) * 64'(elapsed)) / 64'(slope_length);
                    present_level = slope_base + delta[LEVEL_W-1:0];
                end
                else
                begin
                    delta = (64'(slope_base - held_target) * 64'(elapsed)) / 64'(slope_length);
                    present_level = slope_base - delta[LEVEL_W-1:0];
                end
                beat.ramping = 1'b1;
            end
        end
        beat.level = present_level;
        return beat;
    endfunction

    always @(posedge clk)
    begin
        level_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("unexpected output beat: level %0h ramping %0b", m_tdata[LEVEL_W-1:0],
                       m_tuser);
                error_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                beats_checked++;
                if (m_tuser)
                begin
                    ramping_beats++;
                end
                if (m_tdata[LEVEL_W-1:0] !== want.level)
                begin
                    $error("level: expected %0h, actual %0h", want.level, m_tdata[LEVEL_W-1:0]);
                    error_count++;
                end
                if (m_tuser !== want.ramping)
                begin
                    $error("ramping: expected %0b, actual %0b", want.ramping, m_tuser);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(1, 100) <= sink_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6))
                begin
                    @(negedge clk);
                end
                @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_level(logic [LEVEL_W-1:0] target, logic [arl_pkg::TIME_W-1:0] stamp);
        @(negedge clk);
        if ($urandom_range(1, 100) <= send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7))
            begin
                @(negedge clk);
            end
        end
        s_tdata <= {stamp, target};
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        expected_levels.push_back(predict_level(target, stamp));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_access(logic write, logic [arl_pkg::APB_ADDR_W-1:0] addr,
                              logic [arl_pkg::APB_DATA_W-1:0] data,
                              output logic [arl_pkg::APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_reg(logic [arl_pkg::APB_ADDR_W-1:0] addr,
                             logic [arl_pkg::APB_DATA_W-1:0] data);
        logic [arl_pkg::APB_DATA_W-1:0] unused;
        apb_access(1'b1, addr, data, unused);
        if (addr[arl_pkg::APB_ADDR_W-1:2] == arl_pkg::REG_RAMP_TIME)
        begin
            cfg_ramp_time = data[arl_pkg::RAMP_W-1:0];
            settings_used++;
        end
    endtask

    task automatic check_ramp_time_reg();
        logic [arl_pkg::APB_DATA_W-1:0] rdata;
        apb_access(1'b0, ADDR_RAMP_TIME, '0, rdata);
        if (rdata !== arl_pkg::APB_DATA_W'(cfg_ramp_time))
        begin
            $error("ramp_time_ms: expected %0h, actual %0h", cfg_ramp_time, rdata);
            error_count++;
        end
    endtask

    task automatic test_reset_ramp();
        send_level('0, 32'd0);
        send_level('0, 32'd500);
        send_level('0, 32'd999);
        send_level('0, 32'd1000);
        send_level('0, 32'hFFFF_FFFF);
    endtask

    task automatic test_rise_and_fall();
        send_level(LEVEL_MAX, 32'd2000);
        send_level(LEVEL_MAX, 32'd2001);
        send_level(LEVEL_MAX, 32'd3500);
        send_level(LEVEL_MAX, 32'd4999);
        send_level(LEVEL_MAX, 32'd5000);
        // The stamp goes back inside the finished ramp window.
        send_level(LEVEL_MAX, 32'd2005);
        send_level(16'h0010, 32'd6000);
        send_level(16'h0010, 32'd7000);
        send_level(16'h8000, 32'd7000);
        send_level(16'h8000, 32'd7700);
        send_level(present_level, 32'd7800);
        send_level('0, 32'd8000);
    endtask

    task automatic test_zero_ramp_time();
        wait_idle();
        write_reg(ADDR_RAMP_TIME, 32'd0);
        send_level(16'h1234, 32'd9000);
        send_level(16'h1234, 32'd9001);
        send_level(LEVEL_MAX, 32'd9002);
    endtask

    task automatic test_timestamp_wrap();
        wait_idle();
        write_reg(ADDR_RAMP_TIME, 32'd65535);
        send_level('0, 32'hFFFF_FF00);
        send_level(16'hABCD, 32'hFFFF_FFF0);
        send_level(16'hABCD, 32'h0000_0010);
        send_level(16'hABCD, 32'h0000_FFEE);
        send_level(16'hABCD, 32'h0000_FFEF);
        send_level(16'hABCD, 32'h0001_0000);
    endtask

    task automatic test_register_access();
        wait_idle();
        write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
        check_ramp_time_reg();
        write_reg(ADDR_RAMP_TIME, 32'hFFFF_0007);
        check_ramp_time_reg();
        send_level(16'h00F0, 32'd100);
        send_level(16'h00F0, 32'd103);
        send_level(16'h00F0, 32'd107);
    endtask

    task automatic run_ramp_phase(int unsigned n_items, logic [arl_pkg::RAMP_W-1:0] ramp_ms,
                                  int unsigned idle_pct);
        int unsigned i;
        int unsigned pick;
        int unsigned span;
        logic [LEVEL_W-1:0] target;
        logic [arl_pkg::TIME_W-1:0] stamp;
        wait_idle();
        write_reg(ADDR_RAMP_TIME, 32'(ramp_ms));
        check_ramp_time_reg();
        send_idle_pct = idle_pct;
        sink_idle_pct = idle_pct;
        span = ramp_ms / 3 + 4;
        stamp = $urandom;
        target = held_target;
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                stamp += $urandom_range(0, span);
            end
            else if (pick < 62)
            begin
                target = LEVEL_W'($urandom_range(present_level, LEVEL_MAX));
                stamp += $urandom_range(0, 3);
            end
            else if (pick < 76)
            begin
                target = LEVEL_W'($urandom_range(0, present_level));
                stamp += $urandom_range(0, span);
            end
            else if (pick < 84)
            begin
                target = $urandom_range(0, 1) ? LEVEL_MAX : '0;
                stamp += $urandom_range(0, span);
            end
            else if (pick < 92)
            begin
                target = LEVEL_W'($urandom);
                stamp = $urandom;
            end
            else if (pick < 96)
            begin
                stamp += span * 4 + $urandom_range(0, 65535);
            end
            else
            begin
                stamp = slope_stamp + $urandom_range(0, slope_length);
            end
            send_level(target, stamp);
        end
    endtask

    task automatic test_random_traffic();
        run_ramp_phase(270, 16'd1, 20);
        run_ramp_phase(270, 16'd65535, 10);
        run_ramp_phase(270, arl_pkg::RAMP_W'($urandom_range(2, 200)), 30);
        run_ramp_phase(270, 16'd0, 15);
        run_ramp_phase(270, 16'd3000, 25);
        run_ramp_phase(270, arl_pkg::RAMP_W'($urandom_range(1, 65535)), 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        beats_checked = 0;
        ramping_beats = 0;
        items_sent = 0;
        settings_used = 0;
        send_idle_pct = 15;
        sink_idle_pct = 15;
        reset_predictor();
        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_ramp();
        test_rise_and_fall();
        test_zero_ramp_time();
        test_timestamp_wrap();
        test_register_access();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d input beats and checked %0d output beats, %0d of them mid-ramp.",
                 items_sent, beats_checked, ramping_beats);
        $display("Ran under %0d ramp time settings, including zero and full scale.",
                 settings_used);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
